// ===== hdl/text_word_wrap_measure_macros.svh =====
// Assertion macros shared by the checkers of the text measurement block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TEXT_WORD_WRAP_MEASURE_MACROS_SVH
`define TEXT_WORD_WRAP_MEASURE_MACROS_SVH

// Checked only outside reset.
`define TWWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TWWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/twwm_pkg.sv =====
// Shared types, constants and helpers of the text measurement block.
// No dependencies.
`default_nettype none
package twwm_pkg;

    localparam int GLYPH_SLOTS      = 128;
    localparam int GLYPH_IDX_W      = $clog2(GLYPH_SLOTS);
    localparam int CHUNK_SPAN_LIMIT = 16;
    localparam int COORD_BITS       = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] FIRST_GLYPH = 8'd33;
    localparam logic [7:0] CODE_TAB    = 8'd9;
    localparam logic [7:0] CODE_NL     = 8'd10;
    localparam logic [7:0] CODE_FF     = 8'd12;
    localparam logic [7:0] CODE_SPACE  = 8'd32;
    localparam logic [7:0] CODE_HIGH   = 8'd128;
    localparam logic [4:0] SPAN_MAX    = 5'd31;

    localparam logic [2:0] REG_WRAP  = 3'd0;
    localparam logic [2:0] REG_MAXW  = 3'd1;
    localparam logic [2:0] REG_SPACE = 3'd2;
    localparam logic [2:0] REG_LINEH = 3'd3;
    localparam logic [2:0] REG_GCNT  = 3'd4;

    typedef struct packed {
        logic        wrap;
        logic [11:0] max_w;
        logic [5:0]  space_w;
        logic [7:0]  line_h;
        logic [7:0]  glyph_cnt;
    } t_cfg;

    typedef enum logic [2:0] {
        K_LOAD, K_GLYPH, K_FF, K_TAB, K_SPACE, K_NL, K_OTHER
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [GLYPH_IDX_W-1:0] addr;
        logic [7:0]             gwidth;
        logic                   last;
    } t_item;

    function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/twwm_front.sv =====
// Front end: accepts stream transactions, classifies each byte, queues the items.
// Depends on twwm_pkg.
`default_nettype none
module twwm_front import twwm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire logic  i_cmd,
    input  wire logic [7:0] i_code,
    input  wire logic [7:0] i_gwidth,
    input  wire logic  i_last,
    output logic       o_q_valid,
    input  wire logic  i_q_ready,
    output t_item      o_q_item
);

    t_item                  r_q [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wp, r_rp;
    logic [QUEUE_PTR_W:0]   r_cnt;

    t_item      c_item;
    logic       c_keep;
    logic [7:0] c_gidx;
    logic       c_glyph;
    logic       c_push, c_pop;

    always_comb begin
        c_gidx  = i_code - FIRST_GLYPH;
        c_glyph = (i_code >= FIRST_GLYPH) && (i_code < CODE_HIGH)
                  && (c_gidx < i_cfg.glyph_cnt)
                  && ({1'b0, c_gidx} < 9'(GLYPH_SLOTS));
        c_item.gwidth = i_gwidth;
        c_item.last   = i_last;
        c_item.addr   = c_gidx[GLYPH_IDX_W-1:0];
        c_keep        = 1'b1;
        if (!i_cmd) begin
            c_item.kind = K_LOAD;
            c_item.addr = i_code[GLYPH_IDX_W-1:0];
            c_keep      = ({1'b0, i_code} < 9'(GLYPH_SLOTS));
        end else if (c_glyph)              c_item.kind = K_GLYPH;
        else if (i_code == CODE_FF)        c_item.kind = K_FF;
        else if (i_code == CODE_TAB)       c_item.kind = K_TAB;
        else if (i_code == CODE_SPACE)     c_item.kind = K_SPACE;
        else if (i_code == CODE_NL)        c_item.kind = K_NL;
        else                               c_item.kind = K_OTHER;
    end

    assign o_ready   = (r_cnt != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rp];
    assign c_push    = i_valid && o_ready && c_keep;
    assign c_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wp] <= c_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_push) r_wp <= r_wp + 1'b1;
            if (c_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_PTR_W+1)'(c_push) - (QUEUE_PTR_W+1)'(c_pop);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/twwm_back.sv =====
// Back end: glyph width memory, layout state machine, tab-stop divider, result register.
// Depends on twwm_pkg.
`default_nettype none
module twwm_back import twwm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_valid,
    output logic       o_q_ready,
    input  wire t_item i_q_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [COORD_BITS-1:0] o_width,
    output logic [COORD_BITS-1:0] o_height
);

    localparam int CB    = COORD_BITS;
    localparam int CNT_W = $clog2(CB + 2);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_APPLY, S_DIV, S_FIN, S_OUT
    } t_state;

    logic [7:0] r_gmem [GLYPH_SLOTS];

    t_state         r_state;
    t_item          r_item;
    logic [7:0]     r_gw;
    logic [CB-1:0]  r_pen, r_widest, r_height, r_cw;
    logic [4:0]     r_span;
    logic           r_active, r_at_start, r_skip, r_first, r_at0;
    logic [CB:0]    r_sum, r_dq;
    logic [8:0]     r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic           r_m_valid;
    logic [CB-1:0]  r_m_width, r_m_height;

    // chunk close: optional wrap to a new line, then advance past the chunk
    logic [CB:0]   cl_sum;
    logic          cl_wrap;
    logic [CB-1:0] cl_pen, cl_widest, cl_height, cl_base;
    logic [CB:0]   gl_sum;
    logic          gl_break;
    logic [CB-1:0] gw_p1, pen_max, nl_height;
    logic [8:0]    stop;
    logic [9:0]    rem_sh;
    logic [8:0]    rem_nx;
    logic [4:0]    span_p1;
    logic          go_fin;
    logic          ex_apply;
    logic          tab_div;

    always_comb begin
        cl_sum    = {1'b0, r_pen} + {1'b0, r_cw};
        cl_wrap   = i_cfg.wrap && !r_at_start && (cl_sum >= (CB+1)'(i_cfg.max_w));
        pen_max   = (r_pen > r_widest) ? r_pen : r_widest;
        nl_height = sat_add(r_height, CB'(i_cfg.line_h));
        cl_widest = cl_wrap ? pen_max : r_widest;
        cl_height = cl_wrap ? nl_height : r_height;
        cl_base   = cl_wrap ? '0 : r_pen;
        cl_pen    = sat_add(sat_add(cl_base, r_cw), CB'(1));
        gw_p1     = CB'({1'b0, r_gw} + 9'd1);
        gl_sum    = {1'b0, r_cw} + (CB+1)'(gw_p1);
        gl_break  = (r_span > 5'(CHUNK_SPAN_LIMIT)) || (gl_sum >= (CB+1)'(i_cfg.max_w));
        span_p1   = (r_span < SPAN_MAX) ? r_span + 5'd1 : r_span;
        stop      = {i_cfg.space_w, 3'b000};
        rem_sh    = {r_rem, r_dq[CB]};
        rem_nx    = (rem_sh >= {1'b0, stop}) ? 9'(rem_sh - {1'b0, stop}) : rem_sh[8:0];
        go_fin    = r_item.last;
        // bytes that neither skip nor extend a chunk need the apply step
        ex_apply  = !(r_skip || (r_active && r_item.kind == K_FF)
                      || (r_item.kind == K_GLYPH && i_cfg.wrap));
        tab_div   = (r_item.kind == K_TAB) && (stop != '0);
    end

    assign o_q_ready = (r_state == S_IDLE);
    assign o_valid   = r_m_valid;
    assign o_width   = r_m_width;
    assign o_height  = r_m_height;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) begin
            if (i_q_item.kind == K_LOAD) begin
                r_gmem[i_q_item.addr] <= i_q_item.gwidth;
            end
            r_gw <= r_gmem[i_q_item.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pen      <= '0;
            r_widest   <= '0;
            r_height   <= CB'(8'd32);
            r_cw       <= '0;
            r_span     <= '0;
            r_active   <= 1'b0;
            r_at_start <= 1'b0;
            r_skip     <= 1'b0;
            r_first    <= 1'b1;
            r_at0      <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_ready && r_state != S_OUT) r_m_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_q_item.kind != K_LOAD) begin
                        r_item <= i_q_item;
                        r_at0  <= r_first;
                        r_first <= 1'b0;
                        if (r_first) begin
                            r_pen      <= '0;
                            r_widest   <= '0;
                            r_height   <= CB'(i_cfg.line_h);
                            r_cw       <= '0;
                            r_span     <= '0;
                            r_active   <= 1'b0;
                            r_at_start <= 1'b0;
                            r_skip     <= 1'b0;
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= ex_apply ? S_APPLY : (go_fin ? S_FIN : S_IDLE);
                    if (r_skip) begin
                        r_skip <= 1'b0;
                        if (r_active) r_span <= span_p1;
                    end else if (r_active && r_item.kind == K_FF) begin
                        r_span <= span_p1;
                        r_skip <= 1'b1;
                    end else if (r_item.kind == K_GLYPH && i_cfg.wrap) begin
                        if (r_active && gl_break) begin
                            r_pen      <= cl_pen;
                            r_widest   <= cl_widest;
                            r_height   <= cl_height;
                            r_cw       <= CB'(r_gw);
                            r_span     <= '0;
                            r_at_start <= 1'b0;
                        end else if (r_active) begin
                            r_cw   <= sat_add(r_cw, gw_p1);
                            r_span <= span_p1;
                        end else begin
                            r_active   <= 1'b1;
                            r_cw       <= CB'(r_gw);
                            r_span     <= '0;
                            r_at_start <= r_at0;
                        end
                    end else begin
                        if (r_active) begin
                            r_pen      <= cl_pen;
                            r_widest   <= cl_widest;
                            r_height   <= cl_height;
                            r_active   <= 1'b0;
                            r_cw       <= '0;
                            r_span     <= '0;
                            r_at_start <= 1'b0;
                        end
                    end
                end
                S_APPLY: begin
                    r_state <= tab_div ? S_DIV : (go_fin ? S_FIN : S_IDLE);
                    case (r_item.kind)
                        K_TAB: begin
                            if (stop != '0) begin
                                r_sum   <= {1'b0, r_pen} + (CB+1)'(stop);
                                r_dq    <= {1'b0, r_pen} + (CB+1)'(stop);
                                r_rem   <= '0;
                                r_cnt   <= '0;
                            end
                        end
                        K_SPACE: r_pen <= sat_add(r_pen, CB'(i_cfg.space_w));
                        K_NL: begin
                            r_widest <= pen_max;
                            r_pen    <= '0;
                            r_height <= nl_height;
                        end
                        K_FF:    r_skip <= 1'b1;
                        K_GLYPH: r_pen <= sat_add(r_pen, gw_p1);
                        default: ;
                    endcase
                end
                S_DIV: begin
                    // restoring remainder of (pen + stop) / stop, one bit per cycle
                    r_rem <= rem_nx;
                    r_dq  <= {r_dq[CB-1:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CB)) begin
                        r_pen   <= (r_sum - (CB+1)'(rem_nx)) > (CB+1)'({CB{1'b1}})
                                   ? {CB{1'b1}} : CB'(r_sum - (CB+1)'(rem_nx));
                        r_state <= go_fin ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    if (r_active) begin
                        r_pen      <= cl_pen;
                        r_widest   <= cl_widest;
                        r_height   <= cl_height;
                        r_active   <= 1'b0;
                        r_cw       <= '0;
                        r_span     <= '0;
                        r_at_start <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || i_ready) begin
                        r_m_valid  <= 1'b1;
                        r_m_width  <= pen_max;
                        r_m_height <= r_height;
                        r_widest   <= pen_max;
                        r_skip     <= 1'b0;
                        r_first    <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/text_word_wrap_measure.sv =====
// Text measurement block: measures the laid-out width and height of a byte string
// with greedy word wrapping. Input is a stream of text bytes and glyph width loads
// (s_axis), output one transaction per string (m_axis), registers over APB.
// Glyph load: tuser = 0, tdata[7:0] = table index, tdata[15:8] = width.
// Text byte: tuser = 1, tdata[7:0] = byte, tlast marks the final byte of a string.
// Result: m_axis_tdata[15:0] = widest line, [31:16] = total height, both saturated.
// A two-entry queue sits between the classifier and the layout engine, so the
// input keeps accepting, until the queue is full, while the engine works and
// while a result waits. In the layout engine every text byte passes an execute
// step; all but a glyph gathered into a chunk, a skipped byte and a form feed
// inside a chunk then take an apply step, and a tab with a nonzero stop then
// runs a 17-step restoring divider for the tab stop. A final byte then closes
// the chunk and registers the result; a glyph load is written to memory while idle.
// The glyph width memory is read while idle, in the cycle before the execute step.
// Reset clears the queue, layout state and registers to their defaults; glyph
// widths are undefined until loaded. When m_axis_tready is low the result holds
// and the engine stalls at its next final byte; the queue then fills and
// s_axis_tready drops.
`default_nettype none
module text_word_wrap_measure import twwm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // code, glyph_width
    input  wire logic        s_axis_tuser,   // cmd
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // widest line, total height
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg  r_cfg;
    logic  q_valid, q_ready;
    t_item q_item;
    logic [COORD_BITS-1:0] res_w, res_h;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap      <= 1'b0;
            r_cfg.max_w     <= 12'd640;
            r_cfg.space_w   <= 6'd16;
            r_cfg.line_h    <= 8'd32;
            r_cfg.glyph_cnt <= 8'd94;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_WRAP:  r_cfg.wrap      <= pwdata[0];
                REG_MAXW:  r_cfg.max_w     <= pwdata[11:0];
                REG_SPACE: r_cfg.space_w   <= pwdata[5:0];
                REG_LINEH: r_cfg.line_h    <= pwdata[7:0];
                REG_GCNT:  r_cfg.glyph_cnt <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WRAP:  prdata = {31'd0, r_cfg.wrap};
            REG_MAXW:  prdata = {20'd0, r_cfg.max_w};
            REG_SPACE: prdata = {26'd0, r_cfg.space_w};
            REG_LINEH: prdata = {24'd0, r_cfg.line_h};
            REG_GCNT:  prdata = {24'd0, r_cfg.glyph_cnt};
            default:   prdata = '0;
        endcase
    end

    twwm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (s_axis_tuser),
        .i_code    (s_axis_tdata[7:0]),
        .i_gwidth  (s_axis_tdata[15:8]),
        .i_last    (s_axis_tlast),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    twwm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_item  (q_item),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_width   (res_w),
        .o_height  (res_h)
    );

    assign m_axis_tdata = {16'(res_h), 16'(res_w)};

endmodule
`default_nettype wire

// ===== hdl/twwm_check.sv =====
// Port-level checker for the text measurement block, bound to the top level.
// Depends on text_word_wrap_measure_macros.svh.
`default_nettype none
`include "text_word_wrap_measure_macros.svh"
module twwm_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        pready
);

    `TWWM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `TWWM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")
    `TWWM_ASSERT_ALWAYS(a_reset_ready, !i_rst_n |=> s_axis_tready, "input not ready after reset")
    `TWWM_ASSERT(a_apb_ready, 1'b1 |-> pready, "pready dropped")

endmodule

bind text_word_wrap_measure twwm_check u_twwm_check (.*);
`default_nettype wire
